/* rtl/core/chbd_pkg.sv */
// ----------------------------------------------------------------------------
// chbd_pkg
// Shared types and constants of the canonical Huffman bit decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

    localparam int MAX_SYMBOLS  = 32'h100;
    localparam int MAX_CODE_LEN = 32;

    localparam int SYM_W     = 8;
    localparam int LEN_W     = 6;
    localparam int IDX_W     = $clog2(MAX_SYMBOLS);
    localparam int COUNT_W   = $clog2(MAX_SYMBOLS + 1);
    localparam int LEN_IDX_W = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
    localparam int SHAMT_W   = LEN_IDX_W;

    localparam logic [COUNT_W-1:0] TABLE_FULL    = COUNT_W'(MAX_SYMBOLS);
    localparam logic [LEN_W-1:0]   LONGEST_LEGAL = LEN_W'(MAX_CODE_LEN);

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BIT   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic STATUS_FOUND     = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    typedef logic [MAX_CODE_LEN-1:0] code_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [SYM_W-1:0] entry_symbol;
        logic [LEN_W-1:0] entry_length;
        logic             in_bit;
    } cmd_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] out_symbol;
        logic             status;
    } result_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [LEN_W-1:0] length;
        code_t            code;
    } entry_t;

    typedef enum logic [1:0] {
        ALU_NEXT_CODE,
        ALU_SHIFT_IN,
        ALU_MATCH
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [SHAMT_W-1:0] shamt;
        logic               bit_in;
    } alu_ctl_t;

endpackage

/* rtl/core/chbd_mem.sv */
// ----------------------------------------------------------------------------
// chbd_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module chbd_mem
    import chbd_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [MAX_SYMBOLS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/chbd_alu.sv */
// ----------------------------------------------------------------------------
// chbd_alu
// Shared code unit: canonical code step, accumulator shift and code compare.
// ----------------------------------------------------------------------------
module chbd_alu
    import chbd_pkg::*;
(
    input  alu_ctl_t ctl,
    input  code_t    a,
    input  code_t    b,
    output code_t    result,
    output logic     eq
);

    code_t incremented;

    assign incremented = a + code_t'(1);

    always_comb
    begin
        result = a;
        eq     = 1'b0;
        case (ctl.op)
            ALU_NEXT_CODE:
            begin
                result = incremented << ctl.shamt;
            end
            ALU_SHIFT_IN:
            begin
                result = {a[MAX_CODE_LEN-2:0], ctl.bit_in};
            end
            ALU_MATCH:
            begin
                eq = (a == b);
            end
            default:
            begin
                result = a;
            end
        endcase
    end

endmodule

/* rtl/core/canonical_huffman_bit_decoder_top.sv */
// ----------------------------------------------------------------------------
// canonical_huffman_bit_decoder_top
// Bit-serial canonical Huffman decoder with a loadable code table.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-----------------------------
// command  | in        | start high and busy low   | item   (cmd_item_t)
// result   | out       | result_valid, one cycle   | result (result_item_t)
//
// A load passes through the accept cycle and then S_LOAD, in which the shared
// code unit forms the canonical code and the entry is written to the store.
// A clear, an unused command and a rejected load finish in the accept cycle.
// A bit returns to idle after S_BIT when no loaded entry has the new accumulator
// length; otherwise S_WAIT takes a read and a compare step for each entry scanned
// from the first towards the last entry of that length, since the entry store
// has a single registered read port and the shared unit does one compare each.
// Reset empties the table and the accumulator at once; the entry store itself
// is not cleared, as only entries below the fill count are ever read.
// The receiver cannot stall: each result transfer lasts exactly one cycle.
//
module canonical_huffman_bit_decoder_top
    import chbd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  cmd_item_t    item,
    output logic         result_valid,
    output result_item_t result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_BIT,
        S_WAIT
    } state_t;

    // In S_WAIT a read step alternates with a compare step; the compare phase is
    // tracked by a flag so that the state set stays small.
    state_t               state_reg,        state_next;
    logic                 cmp_reg,          cmp_next;
    cmd_item_t            item_reg,         item_next;
    logic [COUNT_W-1:0]   entry_count_reg,  entry_count_next;
    code_t                last_code_reg,    last_code_next;
    logic [LEN_W-1:0]     last_length_reg,  last_length_next;
    code_t                acc_value_reg,    acc_value_next;
    logic [LEN_W-1:0]     acc_length_reg,   acc_length_next;
    logic [LEN_W-1:0]     longest_reg,      longest_next;
    logic [MAX_CODE_LEN-1:0] present_reg,   present_next;
    logic [IDX_W-1:0]     scan_idx_reg,     scan_idx_next;
    logic                 result_valid_reg, result_valid_next;
    result_item_t         result_reg,       result_next;

    // Per-length index: lowest and highest table position of each length.
    logic [IDX_W-1:0] first_idx [MAX_CODE_LEN];
    logic [IDX_W-1:0] last_idx  [MAX_CODE_LEN];

    alu_ctl_t         alu_ctl;
    code_t            alu_a;
    code_t            alu_b;
    code_t            alu_result;
    logic             alu_eq;

    entry_t           wr_entry;
    logic             wr_en;
    entry_t           rd_entry;

    logic             accept;
    logic             load_ok;
    logic [LEN_W-1:0] len_grow;
    logic [LEN_W-1:0] acc_len_inc;
    logic [LEN_W-1:0] inc_len_m1;
    logic [LEN_W-1:0] cur_len_m1;
    logic [LEN_W-1:0] load_len_m1;
    logic [LEN_IDX_W-1:0] inc_slot;
    logic [LEN_IDX_W-1:0] cur_slot;
    logic [LEN_IDX_W-1:0] load_slot;
    logic             entry_hit;

    assign accept  = start && !busy;
    assign busy    = (state_reg != S_IDLE);
    assign load_ok = (entry_count_reg != TABLE_FULL)
                     && (item.entry_length != '0)
                     && (item.entry_length <= LONGEST_LEGAL);

    // Shift amount of the canonical code step: growth in length, if any.
    assign len_grow = (item_reg.entry_length > last_length_reg)
                      ? (item_reg.entry_length - last_length_reg) : '0;

    assign acc_len_inc = acc_length_reg + LEN_W'(1);
    assign inc_len_m1  = acc_len_inc - LEN_W'(1);
    assign cur_len_m1  = acc_length_reg - LEN_W'(1);
    assign load_len_m1 = item_reg.entry_length - LEN_W'(1);
    assign inc_slot    = inc_len_m1[LEN_IDX_W-1:0];
    assign cur_slot    = cur_len_m1[LEN_IDX_W-1:0];
    assign load_slot   = load_len_m1[LEN_IDX_W-1:0];

    // The shared unit's operation follows the sequencer state.
    always_comb
    begin
        alu_ctl.op     = ALU_MATCH;
        alu_ctl.shamt  = len_grow[SHAMT_W-1:0];
        alu_ctl.bit_in = item_reg.in_bit;
        alu_a          = rd_entry.code;
        alu_b          = acc_value_reg;
        case (state_reg)
            S_LOAD:
            begin
                alu_ctl.op = ALU_NEXT_CODE;
                alu_a      = last_code_reg;
            end
            S_BIT:
            begin
                alu_ctl.op = ALU_SHIFT_IN;
                alu_a      = acc_value_reg;
            end
            default:
            begin
                alu_ctl.op = ALU_MATCH;
            end
        endcase
    end

    chbd_alu u_alu
    (
        .ctl    (alu_ctl),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_result),
        .eq     (alu_eq)
    );

    // The first entry of a table always gets code zero.
    assign wr_en           = (state_reg == S_LOAD);
    assign wr_entry.symbol = item_reg.entry_symbol;
    assign wr_entry.length = item_reg.entry_length;
    assign wr_entry.code   = (entry_count_reg == '0) ? '0 : alu_result;

    chbd_mem u_mem
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (entry_count_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_entry)
    );

    assign entry_hit = (rd_entry.length == acc_length_reg) && alu_eq;

    always_comb
    begin
        state_next        = state_reg;
        cmp_next          = cmp_reg;
        item_next         = item_reg;
        entry_count_next  = entry_count_reg;
        last_code_next    = last_code_reg;
        last_length_next  = last_length_reg;
        acc_value_next    = acc_value_reg;
        acc_length_next   = acc_length_reg;
        longest_next      = longest_reg;
        present_next      = present_reg;
        scan_idx_next     = scan_idx_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next = item;
                    case (item.cmd)
                        CMD_LOAD:
                        begin
                            if (load_ok)
                            begin
                                state_next = S_LOAD;
                            end
                        end
                        CMD_BIT:
                        begin
                            state_next = S_BIT;
                        end
                        CMD_CLEAR:
                        begin
                            entry_count_next = '0;
                            last_code_next   = '0;
                            last_length_next = '0;
                            acc_value_next   = '0;
                            acc_length_next  = '0;
                            longest_next     = '0;
                            present_next     = '0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_LOAD:
            begin
                last_code_next   = wr_entry.code;
                last_length_next = item_reg.entry_length;
                entry_count_next = entry_count_reg + COUNT_W'(1);
                present_next[load_slot] = 1'b1;
                if (item_reg.entry_length > longest_reg)
                begin
                    longest_next = item_reg.entry_length;
                end
                state_next = S_IDLE;
            end

            S_BIT:
            begin
                if (present_reg[inc_slot])
                begin
                    acc_value_next  = alu_result;
                    acc_length_next = acc_len_inc;
                    scan_idx_next   = first_idx[inc_slot];
                    cmp_next        = 1'b0;
                    state_next      = S_WAIT;
                end
                else if (acc_len_inc >= longest_reg)
                begin
                    acc_value_next         = '0;
                    acc_length_next        = '0;
                    result_valid_next      = 1'b1;
                    result_next.out_symbol = '0;
                    result_next.status     = STATUS_NOT_FOUND;
                    state_next             = S_IDLE;
                end
                else
                begin
                    acc_value_next  = alu_result;
                    acc_length_next = acc_len_inc;
                    state_next      = S_IDLE;
                end
            end

            S_WAIT:
            begin
                if (!cmp_reg)
                begin
                    // Read data for scan_idx_reg arrives at the next edge.
                    cmp_next = 1'b1;
                end
                else if (entry_hit)
                begin
                    acc_value_next         = '0;
                    acc_length_next        = '0;
                    result_valid_next      = 1'b1;
                    result_next.out_symbol = rd_entry.symbol;
                    result_next.status     = STATUS_FOUND;
                    cmp_next               = 1'b0;
                    state_next             = S_IDLE;
                end
                else if (scan_idx_reg == last_idx[cur_slot])
                begin
                    cmp_next   = 1'b0;
                    state_next = S_IDLE;
                    if (acc_length_reg >= longest_reg)
                    begin
                        acc_value_next         = '0;
                        acc_length_next        = '0;
                        result_valid_next      = 1'b1;
                        result_next.out_symbol = '0;
                        result_next.status     = STATUS_NOT_FOUND;
                    end
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                    cmp_next      = 1'b0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cmp_reg          <= 1'b0;
            entry_count_reg  <= '0;
            last_code_reg    <= '0;
            last_length_reg  <= '0;
            acc_value_reg    <= '0;
            acc_length_reg   <= '0;
            longest_reg      <= '0;
            present_reg      <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cmp_reg          <= cmp_next;
            entry_count_reg  <= entry_count_next;
            last_code_reg    <= last_code_next;
            last_length_reg  <= last_length_next;
            acc_value_reg    <= acc_value_next;
            acc_length_reg   <= acc_length_next;
            longest_reg      <= longest_next;
            present_reg      <= present_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    // Payload registers: the latched command, scan pointer and length index.
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        scan_idx_reg <= scan_idx_next;
        if (state_reg == S_LOAD)
        begin
            if (!present_reg[load_slot])
            begin
                first_idx[load_slot] <= entry_count_reg[IDX_W-1:0];
            end
            last_idx[load_slot] <= entry_count_reg[IDX_W-1:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A result strobe is only ever shown while the sequencer is back in idle.
    a_result_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle");

    // A not-found result carries a zero symbol.
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (result_reg.status == STATUS_NOT_FOUND))
            |-> (result_reg.out_symbol == '0))
        else $error("not-found result with nonzero symbol");

    // The scan never reaches an entry that was not loaded.
    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> (COUNT_W'(scan_idx_reg) < entry_count_reg))
        else $error("scan beyond loaded entries");

    // The accumulator never grows past the longest loaded length.
    a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        acc_length_reg <= longest_reg)
        else $error("accumulator longer than longest code");

    // An accepted bit command always occupies the block for its next cycle.
    a_bit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.cmd == CMD_BIT)) |=> (state_reg == S_BIT))
        else $error("bit command not taken up");

endmodule
